### sv/mfcp_pkg.sv
// Shared constants and types of the marker framed command parser.
// No dependencies; the parser, its front end, queue and emitter and the testbench import this package.
package mfcp_pkg;

    localparam int MAX_PAYLOAD = 64;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int BANKS       = 2;
    localparam int RAM_DEPTH   = STORE_DEPTH * BANKS;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] START_WORD = 32'h0000_002A;
    localparam logic [31:0] END_WORD   = 32'h0000_0023;

    // Stored words per frame, header included.
    localparam logic [6:0] CAP_LEN = 7'(MAX_PAYLOAD);

    // One committed frame handed from the front end to the emitter.
    typedef struct packed {
        logic [31:0]      header;
        logic [IDX_W-1:0] nvals;
        logic             bank;
    } t_frame_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

### sv/mfcp_in_if.sv
// Input word channel: valid/ready handshake with one 32-bit received word.
// Depends on nothing.
interface mfcp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] rx_word;

    modport source (output valid, output rx_word, input ready);
    modport sink   (input valid, input rx_word, output ready);
endinterface

### sv/mfcp_out_if.sv
// Result channel: valid/ready handshake with one decoded command value.
// Depends on nothing.
interface mfcp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  class_id;
    logic [7:0]  channel;
    logic [7:0]  param_index;
    logic [7:0]  value_count;
    logic [31:0] value_word;
    logic [5:0]  value_position;
    logic        value_valid;
    logic        last;

    modport source (output valid, output class_id, output channel, output param_index,
                    output value_count, output value_word, output value_position,
                    output value_valid, output last, input ready);
    modport sink   (input valid, input class_id, input channel, input param_index,
                    input value_count, input value_word, input value_position,
                    input value_valid, input last, output ready);
endinterface

### sv/marker_framed_command_parser.sv
// Marker framed command parser: deframes start/end marked command frames
// from a stream of received 32-bit words and emits one result per value.
// Usage:
//   i_rx  (sink)   one received word per beat. A frame is the start word,
//                  a header (class, channel, index, value count in bits
//                  31..24), value words and the end word. Length is capped
//                  at MAX_PAYLOAD stored words, header included.
//   o_res (source) one beat per stored value, header fields repeated,
//                  last set on the final beat; a header-only frame gives a
//                  single beat with value_valid low. Bad end word: frame dropped.
// Throughput: one input word per cycle. The RAM holds two frame banks, so
// the front end stalls only while it has a frame to store and two finished
// frames are still waiting to be emitted.
// Output: the emitter reads a queued frame's first value (none if header-only) and
// registers it, then one beat per cycle from its RAM read port while ready.
// Reset (synchronous, active low) returns to hunting for the start word and
// empties the descriptor queue; RAM contents need no clearing.
// Receiver stall: the output register holds its beat; the emitter waits,
// and the front end keeps accepting words until both banks are taken.
// Depends on mfcp_pkg, mfcp_in_if, mfcp_out_if and all mfcp_* modules.
module marker_framed_command_parser
    import mfcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfcp_in_if.sink    i_rx,
    mfcp_out_if.source o_res
);

    t_queue_status     q_status;
    t_frame_desc       push_desc;
    t_frame_desc       head_desc;
    logic              push;
    logic              pop;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [31:0]       rd_data;

    // Classify words and fill the write bank.
    mfcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_q_status (q_status),
        .o_push     (push),
        .o_desc     (push_desc),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // Hold committed frames; one entry per RAM bank.
    mfcp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head_desc),
        .o_status (q_status)
    );

    // Two banks of frame storage, bank bit on top of the address.
    mfcp_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Advance through the head frame and drive results.
    mfcp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_desc),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_res      (o_res)
    );

endmodule

### sv/mfcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module mfcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/mfcp_front.sv
// Front end: hunts for the start word, stores header and values into the
// current RAM bank, checks the end word and pushes a frame descriptor.
// Depends on mfcp_pkg and mfcp_in_if.
module mfcp_front
    import mfcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfcp_in_if.sink           i_rx,
    input  t_queue_status     i_q_status,
    output logic              o_push,
    output t_frame_desc       o_desc,
    output logic              o_wr_en,
    output logic [RAM_AW-1:0] o_wr_addr,
    output logic [31:0]       o_wr_data
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_END     = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_word_count, n_word_count;
    logic [8:0]  r_frame_length, n_frame_length;
    logic [31:0] r_header, n_header;
    logic        r_wbank, n_wbank;

    logic        fire;
    logic [6:0]  wc_inc;
    logic [8:0]  len_now;

    // Hold off collecting while both banks hold frames still to be emitted.
    assign i_rx.ready = (r_phase != PH_COLLECT && r_phase != PH_END) || !i_q_status.full;
    assign fire       = i_rx.valid && i_rx.ready;

    assign wc_inc  = r_word_count + 7'd1;
    assign len_now = (r_word_count == 7'd0) ? ({1'b0, i_rx.rx_word[31:24]} + 9'd1)
                                            : r_frame_length;

    assign o_wr_addr = {r_wbank, r_word_count[IDX_W-1:0]};
    assign o_wr_data = i_rx.rx_word;

    assign o_desc.header = r_header;
    assign o_desc.nvals  = IDX_W'(r_word_count - 7'd1);
    assign o_desc.bank   = r_wbank;

    always_comb begin
        n_phase        = r_phase;
        n_word_count   = r_word_count;
        n_frame_length = r_frame_length;
        n_header       = r_header;
        n_wbank        = r_wbank;
        o_wr_en        = 1'b0;
        o_push         = 1'b0;
        if (fire) begin
            unique case (r_phase)
                PH_COLLECT: begin
                    o_wr_en      = 1'b1;
                    n_word_count = wc_inc;
                    if (r_word_count == 7'd0) begin
                        n_frame_length = len_now;
                        n_header       = i_rx.rx_word;
                    end
                    if ({2'b00, wc_inc} == len_now || wc_inc >= CAP_LEN) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    // Commit on a good end word, drop otherwise; never retest as start.
                    if (i_rx.rx_word == END_WORD) begin
                        o_push  = 1'b1;
                        n_wbank = !r_wbank;
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_rx.rx_word == START_WORD) begin
                        n_word_count = 7'd0;
                        n_phase      = PH_COLLECT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_word_count   <= 7'd0;
            r_frame_length <= 9'd0;
            r_wbank        <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_word_count   <= n_word_count;
            r_frame_length <= n_frame_length;
            r_wbank        <= n_wbank;
        end
        r_header <= n_header;
    end

endmodule

### sv/mfcp_queue.sv
// Two-entry descriptor queue between the front end and the emitter.
// Depends on mfcp_pkg.
module mfcp_queue
    import mfcp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_frame_desc   i_desc,
    input  logic          i_pop,
    output t_frame_desc   o_head,
    output t_queue_status o_status
);

    t_frame_desc       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

### sv/mfcp_back.sv
// Emitter: takes the head frame descriptor, reads its values from the RAM
// bank and drives one result per value (a single one for a header-only frame) through an output register.
// Depends on mfcp_pkg and mfcp_out_if.
module mfcp_back
    import mfcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame_desc       i_head,
    input  t_queue_status     i_q_status,
    output logic              o_pop,
    output logic              o_rd_en,
    output logic [RAM_AW-1:0] o_rd_addr,
    input  logic [31:0]       i_rd_data,
    mfcp_out_if.source        o_res
);

    typedef enum logic {
        B_IDLE = 1'b0,
        B_EMIT = 1'b1
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_valid, n_valid;
    logic [31:0]      r_header, n_header;
    logic [31:0]      r_value, n_value;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic             r_vvalid, n_vvalid;
    logic             r_last, n_last;

    logic             out_free;
    logic [IDX_W:0]   k_inc;

    assign out_free = !r_valid || o_res.ready;
    assign k_inc    = {1'b0, r_k} + (IDX_W + 1)'(1);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_valid   = r_valid && !o_res.ready;
        n_header  = r_header;
        n_value   = r_value;
        n_pos     = r_pos;
        n_vvalid  = r_vvalid;
        n_last    = r_last;
        o_pop     = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = {i_head.bank, IDX_W'(1)};
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_head.nvals == '0) begin
                        // Header-only frame: a single result, no RAM read.
                        if (out_free) begin
                            n_valid  = 1'b1;
                            n_header = i_head.header;
                            n_value  = 32'd0;
                            n_pos    = '0;
                            n_vvalid = 1'b0;
                            n_last   = 1'b1;
                            o_pop    = 1'b1;
                        end
                    end else begin
                        o_rd_en = 1'b1;
                        n_k     = '0;
                        n_state = B_EMIT;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_valid  = 1'b1;
                    n_header = i_head.header;
                    n_value  = i_rd_data;
                    n_pos    = r_k;
                    n_vvalid = 1'b1;
                    n_last   = (k_inc == {1'b0, i_head.nvals});
                    if (k_inc == {1'b0, i_head.nvals}) begin
                        o_pop   = 1'b1;
                        n_state = B_IDLE;
                    end else begin
                        // Prefetch the next value while this one goes out.
                        n_k       = k_inc[IDX_W-1:0];
                        o_rd_en   = 1'b1;
                        o_rd_addr = {i_head.bank, IDX_W'(k_inc + (IDX_W + 1)'(1))};
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
        r_header <= n_header;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_vvalid <= n_vvalid;
        r_last   <= n_last;
    end

    assign o_res.valid          = r_valid;
    assign o_res.class_id       = r_header[7:0];
    assign o_res.channel        = r_header[15:8];
    assign o_res.param_index    = r_header[23:16];
    assign o_res.value_count    = r_header[31:24];
    assign o_res.value_word     = r_value;
    assign o_res.value_position = r_pos;
    assign o_res.value_valid    = r_vvalid;
    assign o_res.last           = r_last;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the marker framed command parser.
// Depends on mfcp_pkg, mfcp_in_if, mfcp_out_if and the parser RTL.
module tb_top
    import mfcp_pkg::*;
();

    // Cycles without any beat on either side before the run is abandoned.
    // The longest natural quiet stretch is a short random idle/stall streak
    // plus the end-of-run drain, so this is generous by a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIRECTED_WORDS = 18;
    localparam int WORDS_PER_PHASE = 125;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_COLLECT,
        PH_AWAIT_END
    } t_parse_phase;

    typedef struct packed {
        logic [7:0]  class_id;
        logic [7:0]  channel;
        logic [7:0]  param_index;
        logic [7:0]  value_count;
        logic [31:0] value_word;
        logic [5:0]  value_position;
        logic        value_valid;
        logic        last;
    } t_cmd_value;

    // Tracks the frame parse state from accepted words and queues the value
    // beats each completed frame must produce, oldest first.
    class cmd_deframer;
        t_parse_phase phase = PH_HUNT;
        logic [6:0]   stored = '0;
        logic [8:0]   frame_len = '0;
        logic [31:0]  store [STORE_DEPTH];
        t_cmd_value   queued_values [$];
        int errors = 0;
        int frames_emitted = 0;
        int frames_dropped = 0;
        int beats_checked = 0;

        function void take_word(logic [31:0] w);
            t_cmd_value v;
            int nvals;
            int total;
            case (phase)
                PH_COLLECT: begin
                    if (stored == 0) frame_len = {1'b0, w[31:24]} + 9'd1;
                    store[stored[5:0]] = w;
                    stored = stored + 7'd1;
                    if ({2'b00, stored} == frame_len || stored >= CAP_LEN) phase = PH_AWAIT_END;
                end
                PH_AWAIT_END: begin
                    if (w == END_WORD) begin
                        nvals = int'(stored) - 1;
                        total = (nvals == 0) ? 1 : nvals;
                        for (int k = 0; k < total; k++) begin
                            v.class_id       = store[0][7:0];
                            v.channel        = store[0][15:8];
                            v.param_index    = store[0][23:16];
                            v.value_count    = store[0][31:24];
                            v.value_word     = (nvals == 0) ? 32'd0 : store[k + 1];
                            v.value_position = (nvals == 0) ? 6'd0 : 6'(k);
                            v.value_valid    = (nvals != 0);
                            v.last           = (k + 1 == total);
                            queued_values.push_back(v);
                        end
                        frames_emitted++;
                    end else begin
                        frames_dropped++;
                    end
                    phase = PH_HUNT;
                end
                default: begin
                    // The word after a dropped frame lands here too, so a
                    // start word there is honored only when already hunting.
                    phase = PH_HUNT;
                    if (w == START_WORD) begin
                        stored = '0;
                        phase = PH_COLLECT;
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void match_value(t_cmd_value got);
            t_cmd_value want;
            if (queued_values.size() == 0) begin
                errors++;
                $display("%0t: unexpected value beat %h", $time, got);
                return;
            end
            want = queued_values.pop_front();
            beats_checked++;
            check_field("class_id", 32'(want.class_id), 32'(got.class_id));
            check_field("channel", 32'(want.channel), 32'(got.channel));
            check_field("param_index", 32'(want.param_index), 32'(got.param_index));
            check_field("value_count", 32'(want.value_count), 32'(got.value_count));
            check_field("value_word", want.value_word, got.value_word);
            check_field("value_position", 32'(want.value_position), 32'(got.value_position));
            check_field("value_valid", 32'(want.value_valid), 32'(got.value_valid));
            check_field("last", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return queued_values.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mfcp_in_if  rx_if ();
    mfcp_out_if res_if ();

    marker_framed_command_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    cmd_deframer sb = new;

    int words_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    // Receiver side: decide the stall for the coming edge at each falling edge.
    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99, 0) >= stall_pct);
    end

    // Check every result beat at the rising edge that accepts it.
    always @(posedge i_clk) begin
        t_cmd_value got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.class_id       = res_if.class_id;
            got.channel        = res_if.channel;
            got.param_index    = res_if.param_index;
            got.value_count    = res_if.value_count;
            got.value_word     = res_if.value_word;
            got.value_position = res_if.value_position;
            got.value_valid    = res_if.value_valid;
            got.last           = res_if.last;
            sb.match_value(got);
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d value beats still expected",
                     $time, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Send one word: insert random idle cycles, hold the beat until it is
    // taken, then advance to the next falling edge. Valid stays high when
    // the next call sends without idling.
    task automatic push_word(input logic [31:0] w);
        while ($urandom_range(99, 0) < idle_pct) begin
            rx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_word = w;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sb.take_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Send a whole frame with random payload; the payload length follows
    // the header's count byte, capped at the store size.
    task automatic send_frame(input logic [31:0] header, input logic [31:0] end_w);
        int n_words;
        logic [31:0] w;
        n_words = int'(header[31:24]) + 1;
        if (n_words > MAX_PAYLOAD) n_words = MAX_PAYLOAD;
        push_word(START_WORD);
        push_word(header);
        for (int i = 1; i < n_words; i++) begin
            // Drop a marker word into the payload now and then.
            case ($urandom_range(15, 0))
                0:       w = START_WORD;
                1:       w = END_WORD;
                default: w = $urandom;
            endcase
            push_word(w);
        end
        push_word(end_w);
    endtask

    function automatic logic [31:0] bad_end_word();
        logic [31:0] w;
        w = ($urandom_range(2, 0) == 0) ? START_WORD : $urandom;
        if (w == END_WORD) w = START_WORD;
        return w;
    endfunction

    initial begin
        int idle_plan [4];
        int stall_plan [4];
        int roll;
        logic [7:0] cnt;

        // Phases: clean, sender gaps, receiver stalls, both.
        idle_plan  = '{0, 45, 0, 16};
        stall_plan = '{0, 0, 45, 16};

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_word = '0;
        res_if.ready  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        // An end word while hunting is ignored.
        push_word(END_WORD);
        // Header-only frame with class, channel and index all ones.
        push_word(START_WORD);
        push_word(32'h00FF_FFFF);
        push_word(END_WORD);
        // Two values, all ones and a start word carried as plain data.
        push_word(START_WORD);
        push_word(32'h0200_0000);
        push_word(32'hFFFF_FFFF);
        push_word(START_WORD);
        push_word(END_WORD);
        // Wrong end word that is itself a start word: drop the frame and do
        // not restart on it, so the following zero header and end word
        // must produce nothing.
        push_word(START_WORD);
        push_word(32'h0112_3456);
        push_word(32'h0000_0000);
        push_word(START_WORD);
        push_word(32'h0000_0000);
        push_word(END_WORD);
        // Header-only frame with an all-zero header.
        push_word(START_WORD);
        push_word(32'h0000_0000);
        push_word(END_WORD);

        // Random part, one block of words per idling phase.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            if (p == 0) begin
                // Declared count above the cap, then a count that fills it exactly.
                send_frame({8'hFF, 24'($urandom)}, END_WORD);
                send_frame({8'(MAX_PAYLOAD - 1), 24'($urandom)}, END_WORD);
            end
            while (words_sent < DIRECTED_WORDS + WORDS_PER_PHASE * (p + 1)) begin
                roll = $urandom_range(99, 0);
                cnt  = ($urandom_range(99, 0) < 4) ? 8'($urandom) : 8'($urandom_range(6, 0));
                if (roll < 75) begin
                    send_frame({cnt, 24'($urandom)}, END_WORD);
                end else if (roll < 87) begin
                    send_frame({cnt, 24'($urandom)}, bad_end_word());
                end else begin
                    // Line noise, small values hit the marker codes now and then.
                    repeat ($urandom_range(3, 1)) begin
                        push_word($urandom_range(1, 0) ? 32'($urandom_range(63, 0)) : $urandom);
                    end
                end
            end
        end
        rx_if.valid = 1'b0;

        // Drain: wait for every expected beat, then let the clock run on in case
        // anything unexpected trails behind.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words over four idling phases: %0d frames emitted, %0d dropped,",
                 words_sent, sb.frames_emitted, sb.frames_dropped);
        $display("%0d value beats checked, %0d mismatches", sb.beats_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
